[rtl/core/rra_pkg.sv]
// Shared types and constants for the rounded rectangle antialiasing pixel block.
package rra_pkg;

  localparam int PIX_W   = 11;  // pixel coordinate width
  localparam int DIM_W   = 12;  // rectangle side register width
  localparam int RAD_W   = 11;  // corner radius register width
  localparam int CH_W    = 8;   // color channel width
  localparam int CFG_W   = 12;  // config write data width
  localparam int ADDR_W  = 3;   // config register index width
  localparam int RAD_MAX = (1 << RAD_W) - 1;

  typedef enum logic [ADDR_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_RADIUS = 3'd2,
    REG_RED    = 3'd3,
    REG_GREEN  = 3'd4,
    REG_BLUE   = 3'd5,
    REG_ALPHA  = 3'd6
  } rra_reg_e;

  localparam logic [DIM_W-1:0] RST_WIDTH  = 12'd64;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 12'd32;
  localparam logic [RAD_W-1:0] RST_RADIUS = 11'd10;
  localparam logic [CH_W-1:0]  RST_COLOR  = 8'd50;
  localparam logic [CH_W-1:0]  RST_ALPHA  = 8'd255;

  typedef struct packed {
    logic valid;
    logic in_rect;
  } rra_ctrl_t;

endpackage

[rtl/core/rra_cover.sv]
// Four-stage subsample coverage pipeline: scaled coordinates, corner distances, squares, test.
module rra_cover #(
  parameter int SUPERSAMPLE = 3,
  parameter int MAX_SIDE    = 2048
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        valid_i,
  input  logic [rra_pkg::PIX_W-1:0]                   pixel_x_i,
  input  logic [rra_pkg::PIX_W-1:0]                   pixel_y_i,
  input  logic [$clog2(MAX_SIDE+1)-1:0]               side_w_i,
  input  logic [$clog2(MAX_SIDE+1)-1:0]               side_h_i,
  input  logic [rra_pkg::RAD_W-1:0]                   corner_radius_i,
  output rra_pkg::rra_ctrl_t                          ctrl_o,
  output logic [SUPERSAMPLE*SUPERSAMPLE-1:0]          cover_o
);
  import rra_pkg::*;

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int D_W    = $clog2((MAX_SIDE + RAD_MAX) * SUPERSAMPLE + 2);
  localparam int RS_W   = $clog2(RAD_MAX * SUPERSAMPLE + 1);
  localparam int SQ_W   = 2 * RS_W;
  localparam int SUM_W  = SQ_W + 1;

  // scaled distance past the inner corner-circle center; left/top wins
  function automatic logic [RS_W-1:0] corner_dist(input logic [D_W-1:0] s,
                                                  input logic [D_W-1:0] side,
                                                  input logic [D_W-1:0] r);
    logic [D_W-1:0] d;
    if (s < r) begin
      d = r - s;
    end else if (s + r >= side) begin
      d = s + r + D_W'(1) - side;
    end else begin
      d = '0;
    end
    return d[RS_W-1:0];
  endfunction

  logic [D_W-1:0]  sw, sh, sr;
  logic [RS_W-1:0] sr_n;

  assign sw   = D_W'(side_w_i) * D_W'(SUPERSAMPLE);
  assign sh   = D_W'(side_h_i) * D_W'(SUPERSAMPLE);
  assign sr   = D_W'(corner_radius_i) * D_W'(SUPERSAMPLE);
  assign sr_n = sr[RS_W-1:0];

  rra_ctrl_t       ctrl1_d, ctrl1_q, ctrl2_q, ctrl3_q, ctrl4_q;
  logic [D_W-1:0]  sx_q [SUPERSAMPLE];
  logic [D_W-1:0]  sy_q [SUPERSAMPLE];
  logic [RS_W-1:0] dx_q [SUPERSAMPLE];
  logic [RS_W-1:0] dy_q [SUPERSAMPLE];
  logic [SQ_W-1:0] qx_q [SUPERSAMPLE];
  logic [SQ_W-1:0] qy_q [SUPERSAMPLE];
  logic [SQ_W-1:0] sr2_q;
  logic [SUPERSAMPLE*SUPERSAMPLE-1:0] cover_d, cover_q;

  always_comb begin
    ctrl1_d.valid   = valid_i;
    ctrl1_d.in_rect = (SIDE_W'(0) != side_w_i) &&
                      (32'(pixel_x_i) < 32'(side_w_i)) &&
                      (32'(pixel_y_i) < 32'(side_h_i));
  end

  always_comb begin
    for (int j = 0; j < SUPERSAMPLE; j++) begin
      for (int i = 0; i < SUPERSAMPLE; i++) begin
        cover_d[j*SUPERSAMPLE+i] = (SUM_W'(qx_q[i]) + SUM_W'(qy_q[j])) <= SUM_W'(sr2_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl1_q <= '0;
      ctrl2_q <= '0;
      ctrl3_q <= '0;
      ctrl4_q <= '0;
    end else begin
      ctrl1_q <= ctrl1_d;
      ctrl2_q <= ctrl1_q;
      ctrl3_q <= ctrl2_q;
      ctrl4_q <= ctrl3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < SUPERSAMPLE; k++) begin
      sx_q[k] <= D_W'(pixel_x_i) * D_W'(SUPERSAMPLE) + D_W'(k);
      sy_q[k] <= D_W'(pixel_y_i) * D_W'(SUPERSAMPLE) + D_W'(k);
      dx_q[k] <= corner_dist(sx_q[k], sw, sr);
      dy_q[k] <= corner_dist(sy_q[k], sh, sr);
      qx_q[k] <= SQ_W'(dx_q[k]) * SQ_W'(dx_q[k]);
      qy_q[k] <= SQ_W'(dy_q[k]) * SQ_W'(dy_q[k]);
    end
    sr2_q   <= SQ_W'(sr_n) * SQ_W'(sr_n);
    cover_q <= cover_d;
  end

  assign ctrl_o  = ctrl4_q;
  assign cover_o = cover_q;

endmodule

[rtl/core/rounded_rect_antialias_pixel.sv]
// Top level of the antialiased rounded rectangle pixel block.
// Usage: a pixel (pixel_x_i, pixel_y_i) is taken at every rising edge where
// start_i is high and busy_o is low; busy_o is always low, so one pixel can
// be issued every clock. The pixel is cut into SUPERSAMPLE x SUPERSAMPLE
// subsamples, each tested against the scaled corner circles in parallel.
// Its RGBA color appears on red_out_o/green_out_o/blue_out_o/alpha_out_o
// with done_o high for one cycle, once it has passed the whole pipeline;
// results leave in issue order, one per clock at most. Pipeline: scaled
// coordinates, corner distances, squares, circle test, coverage times
// fill, divide by the subsample count through a constant reciprocal multiply.
// Pixels outside the rectangle come out as all zeros.
// Config: cfg_we_i writes cfg_wdata_i into the register selected by
// cfg_addr_i (width, height, radius, red, green, blue, alpha); unknown
// indices are dropped. Write only while no pixel is in flight.
// Reset empties the pipeline and loads the default geometry and colors.
// The receiver cannot stall: results must be taken when done_o is high.
module rounded_rect_antialias_pixel #(
  parameter int SUPERSAMPLE = 3,
  parameter int MAX_SIDE    = 2048
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [rra_pkg::PIX_W-1:0]    pixel_x_i,
  input  logic [rra_pkg::PIX_W-1:0]    pixel_y_i,
  input  logic                         cfg_we_i,
  input  logic [rra_pkg::ADDR_W-1:0]   cfg_addr_i,
  input  logic [rra_pkg::CFG_W-1:0]    cfg_wdata_i,
  output logic                         done_o,
  output logic [rra_pkg::CH_W-1:0]     red_out_o,
  output logic [rra_pkg::CH_W-1:0]     green_out_o,
  output logic [rra_pkg::CH_W-1:0]     blue_out_o,
  output logic [rra_pkg::CH_W-1:0]     alpha_out_o
);
  import rra_pkg::*;

  localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
  localparam int AREA    = SUPERSAMPLE * SUPERSAMPLE;
  localparam int CNT_W   = $clog2(AREA + 1);
  localparam int PROD_W  = CNT_W + CH_W;
  localparam int SHIFT   = PROD_W + 5;
  localparam int RECIP   = ((1 << SHIFT) + AREA - 1) / AREA;
  localparam int RECIP_W = SHIFT + 1;
  localparam int QUO_W   = PROD_W + RECIP_W;

  logic [DIM_W-1:0] rect_width_q, rect_height_q;
  logic [RAD_W-1:0] corner_radius_q;
  logic [CH_W-1:0]  fill_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_width_q    <= RST_WIDTH;
      rect_height_q   <= RST_HEIGHT;
      corner_radius_q <= RST_RADIUS;
      fill_q[0]       <= RST_COLOR;
      fill_q[1]       <= RST_COLOR;
      fill_q[2]       <= RST_COLOR;
      fill_q[3]       <= RST_ALPHA;
    end else if (cfg_we_i) begin
      case (rra_reg_e'(cfg_addr_i))
        REG_WIDTH:  rect_width_q    <= cfg_wdata_i[DIM_W-1:0];
        REG_HEIGHT: rect_height_q   <= cfg_wdata_i[DIM_W-1:0];
        REG_RADIUS: corner_radius_q <= cfg_wdata_i[RAD_W-1:0];
        REG_RED:    fill_q[0]       <= cfg_wdata_i[CH_W-1:0];
        REG_GREEN:  fill_q[1]       <= cfg_wdata_i[CH_W-1:0];
        REG_BLUE:   fill_q[2]       <= cfg_wdata_i[CH_W-1:0];
        REG_ALPHA:  fill_q[3]       <= cfg_wdata_i[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // sides saturate at MAX_SIDE
  logic [SIDE_W-1:0] side_w, side_h;

  always_comb begin
    if (32'(rect_width_q) > 32'(MAX_SIDE)) begin
      side_w = SIDE_W'(MAX_SIDE);
    end else begin
      side_w = SIDE_W'(rect_width_q);
    end
    if (32'(rect_height_q) > 32'(MAX_SIDE)) begin
      side_h = SIDE_W'(MAX_SIDE);
    end else begin
      side_h = SIDE_W'(rect_height_q);
    end
  end

  rra_ctrl_t        cov_ctrl;
  logic [AREA-1:0]  cover_bits;

  rra_cover #(
    .SUPERSAMPLE (SUPERSAMPLE),
    .MAX_SIDE    (MAX_SIDE)
  ) u_cover (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (start_i && !busy_o),
    .pixel_x_i       (pixel_x_i),
    .pixel_y_i       (pixel_y_i),
    .side_w_i        (side_w),
    .side_h_i        (side_h),
    .corner_radius_i (corner_radius_q),
    .ctrl_o          (cov_ctrl),
    .cover_o         (cover_bits)
  );

  // coverage count, forced to zero outside the rectangle
  logic [CNT_W-1:0] count;

  always_comb begin
    count = '0;
    for (int k = 0; k < AREA; k++) begin
      count = count + CNT_W'(cover_bits[k]);
    end
    if (!cov_ctrl.in_rect) begin
      count = '0;
    end
  end

  logic              valid5_q, done_q;
  logic [PROD_W-1:0] prod_q [4];
  logic [QUO_W-1:0]  quo    [4];
  logic [CH_W-1:0]   chan_q [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      quo[c] = QUO_W'(prod_q[c]) * QUO_W'(RECIP);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid5_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      valid5_q <= cov_ctrl.valid;
      done_q   <= valid5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      prod_q[c] <= PROD_W'(count) * PROD_W'(fill_q[c]);
      chan_q[c] <= quo[c][SHIFT +: CH_W];
    end
  end

  assign busy_o      = 1'b0;
  assign done_o      = done_q;
  assign red_out_o   = chan_q[0];
  assign green_out_o = chan_q[1];
  assign blue_out_o  = chan_q[2];
  assign alpha_out_o = chan_q[3];

endmodule

[bench/tb_top.sv]
// Self-checking bench for the rounded rectangle antialiasing pixel block.
`timescale 1ns / 1ps

module tb_top;
  import rra_pkg::*;

  localparam int SS          = 3;
  localparam int MAX_SIDE    = 2048;
  localparam int LATENCY     = 6;
  localparam int SETTLE      = LATENCY + 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 125;
  localparam int PIX_MAX     = (1 << PIX_W) - 1;

  // index with no register behind it; writes must be dropped
  localparam logic [ADDR_W-1:0] REG_NONE = 3'd7;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } rgba_t;

  class rra_scoreboard;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [RAD_W-1:0] radius;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  alpha;
    rgba_t            color_q[$];
    int               errors;

    function new();
      width  = RST_WIDTH;
      height = RST_HEIGHT;
      radius = RST_RADIUS;
      red    = RST_COLOR;
      green  = RST_COLOR;
      blue   = RST_COLOR;
      alpha  = RST_ALPHA;
      errors = 0;
    endfunction

    function void write_reg(logic [ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_WIDTH:  width  = val[DIM_W-1:0];
        REG_HEIGHT: height = val[DIM_W-1:0];
        REG_RADIUS: radius = val[RAD_W-1:0];
        REG_RED:    red    = val[CH_W-1:0];
        REG_GREEN:  green  = val[CH_W-1:0];
        REG_BLUE:   blue   = val[CH_W-1:0];
        REG_ALPHA:  alpha  = val[CH_W-1:0];
        default: ;
      endcase
    endfunction

    // scaled distance past the inner circle center; low side wins on overlap
    static function longint circle_offset(longint s, longint side, longint r);
      if (s < r) return r - s;
      if (s >= side - r) return s - (side - r - 1);
      return 0;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
      int     w, h, i, j, covered;
      longint sr, sr2, dx, dy;
      rgba_t  c;
      w = (width > MAX_SIDE) ? MAX_SIDE : int'(width);
      h = (height > MAX_SIDE) ? MAX_SIDE : int'(height);
      c = '0;
      covered = 0;
      if (int'(px) < w && int'(py) < h) begin
        sr  = longint'(radius) * SS;
        sr2 = sr * sr;
        for (j = 0; j < SS; j++) begin
          dy = circle_offset(longint'(py) * SS + j, longint'(h) * SS, sr);
          for (i = 0; i < SS; i++) begin
            dx = circle_offset(longint'(px) * SS + i, longint'(w) * SS, sr);
            if (dx * dx + dy * dy <= sr2) covered++;
          end
        end
        c.red   = CH_W'((covered * int'(red)) / (SS * SS));
        c.green = CH_W'((covered * int'(green)) / (SS * SS));
        c.blue  = CH_W'((covered * int'(blue)) / (SS * SS));
        c.alpha = CH_W'((covered * int'(alpha)) / (SS * SS));
      end
      color_q.push_back(c);
    endfunction

    function void compare_channel(string name, logic [CH_W-1:0] exp_v,
                                  logic [CH_W-1:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check(rgba_t got);
      rgba_t exp_c;
      if (color_q.size() == 0) begin
        $error("done_o with no pixel outstanding");
        errors++;
      end else begin
        exp_c = color_q.pop_front();
        compare_channel("red_out", exp_c.red, got.red);
        compare_channel("green_out", exp_c.green, got.green);
        compare_channel("blue_out", exp_c.blue, got.blue);
        compare_channel("alpha_out", exp_c.alpha, got.alpha);
      end
    endfunction

    function int pending();
      return color_q.size();
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start_i     = 1'b0;
  logic [PIX_W-1:0]  pixel_x_i   = '0;
  logic [PIX_W-1:0]  pixel_y_i   = '0;
  logic              cfg_we_i    = 1'b0;
  logic [ADDR_W-1:0] cfg_addr_i  = '0;
  logic [CFG_W-1:0]  cfg_wdata_i = '0;
  logic              busy_o;
  logic              done_o;
  logic [CH_W-1:0]   red_out_o;
  logic [CH_W-1:0]   green_out_o;
  logic [CH_W-1:0]   blue_out_o;
  logic [CH_W-1:0]   alpha_out_o;

  rra_scoreboard sb;
  int            cycle_count = 0;

  rounded_rect_antialias_pixel #(
    .SUPERSAMPLE(SS),
    .MAX_SIDE   (MAX_SIDE)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .red_out_o  (red_out_o),
    .green_out_o(green_out_o),
    .blue_out_o (blue_out_o),
    .alpha_out_o(alpha_out_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[rounded_rect_antialias_pixel] ERROR");
      $finish;
    end
  end

  // results cannot be held off: every done_o cycle is a transfer
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check({red_out_o, green_out_o, blue_out_o, alpha_out_o});
  end

  // start_i is left high; the caller lowers it when a gap follows
  task automatic send_pixel(input int x, input int y);
    start_i   <= 1'b1;
    pixel_x_i <= PIX_W'(x);
    pixel_y_i <= PIX_W'(y);
    do @(posedge clk_i); while (busy_o);
    sb.note_pixel(PIX_W'(x), PIX_W'(y));
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // writes every register plus the unmapped index; junk in the unused upper bits
  task automatic program_config(input int w, input int h, input int r, input int cr,
                                input int cg, input int cb, input int ca);
    logic [ADDR_W-1:0] reg_order[8];
    logic [CFG_W-1:0]  vals[8];
    int                k;
    reg_order = '{REG_WIDTH, REG_HEIGHT, REG_RADIUS, REG_RED, REG_GREEN, REG_BLUE,
                  REG_ALPHA, REG_NONE};
    vals[0] = CFG_W'(w);
    vals[1] = CFG_W'(h);
    vals[2] = {1'($urandom), RAD_W'(r)};
    vals[3] = {4'($urandom), CH_W'(cr)};
    vals[4] = {4'($urandom), CH_W'(cg)};
    vals[5] = {4'($urandom), CH_W'(cb)};
    vals[6] = {4'($urandom), CH_W'(ca)};
    vals[7] = CFG_W'($urandom);
    for (k = 0; k < 8; k++) begin
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= reg_order[k];
      cfg_wdata_i <= vals[k];
      @(posedge clk_i);
      sb.write_reg(reg_order[k], vals[k]);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // biased toward the corner bands and the far edges of the rectangle
  function automatic int pick_coord(int side, int r);
    int s, v;
    s = (side > MAX_SIDE) ? MAX_SIDE : side;
    if (s == 0) return $urandom_range(0, PIX_MAX);
    case ($urandom_range(0, 7))
      0:       v = $urandom_range(0, PIX_MAX);
      1, 2:    v = $urandom_range(0, r + 2);
      3, 4:    v = s - 1 - int'($urandom_range(0, r + 2));
      5:       v = s + $urandom_range(0, 2);
      default: v = $urandom_range(0, s - 1);
    endcase
    if (v < 0) v = 0;
    if (v > PIX_MAX) v = PIX_MAX;
    return v;
  endfunction

  function automatic int pick_channel();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic int pick_extreme_side();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 1;
      2:       return 2;
      3:       return 2047;
      4:       return 2048;
      default: return 4095;
    endcase
  endfunction

  task automatic random_config(input int phase);
    int mode, w, h, r;
    mode = (phase < 2) ? 7 : $urandom_range(0, 9);
    if (mode == 7) begin
      w = pick_extreme_side();
      h = pick_extreme_side();
      case ($urandom_range(0, 4))
        0:       r = 0;
        1:       r = 1;
        2:       r = 1023;
        3:       r = 1024;
        default: r = RAD_MAX;
      endcase
    end else if (mode == 8) begin
      w = $urandom_range(0, 4095);
      h = $urandom_range(0, 4095);
      r = $urandom_range(0, RAD_MAX);
    end else if (mode == 9) begin
      w = $urandom_range(1, 300);
      h = $urandom_range(1, 300);
      r = $urandom_range(0, 200);
    end else begin
      w = $urandom_range(1, 48);
      h = $urandom_range(1, 48);
      r = $urandom_range(0, 30);
    end
    program_config(w, h, r, pick_channel(), pick_channel(), pick_channel(),
                   pick_channel());
  endtask

  initial begin
    int phase, sent, burst, k;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: corners, edges, just outside, far outside, middle band
    send_pixel(0, 0);
    send_pixel(63, 31);
    send_pixel(63, 0);
    send_pixel(0, 31);
    send_pixel(64, 0);
    send_pixel(0, 32);
    send_pixel(PIX_MAX, PIX_MAX);
    send_pixel(10, 10);
    send_pixel(9, 3);
    send_pixel(32, 16);
    drain();
    // zero width: everything outside
    program_config(0, 32, 10, 255, 255, 255, 255);
    send_pixel(0, 0);
    drain();
    // zero radius: full fill everywhere inside
    program_config(5, 7, 0, 255, 128, 1, 255);
    send_pixel(0, 0);
    send_pixel(4, 6);
    send_pixel(2, 3);
    drain();
    // radius beyond half a side: low-side offset takes priority
    program_config(4, 4, 1024, 200, 100, 50, 255);
    send_pixel(0, 0);
    send_pixel(1, 2);
    send_pixel(3, 3);
    drain();
    // sides above the maximum saturate
    program_config(4095, 4095, RAD_MAX, 255, 0, 255, 0);
    send_pixel(PIX_MAX, PIX_MAX);
    send_pixel(0, 0);
    send_pixel(PIX_MAX, 0);
    send_pixel(1023, 1023);
    drain();

    for (phase = 0; phase < PHASES; phase++) begin
      random_config(phase);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 40);
        for (k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
          send_pixel(pick_coord(int'(sb.width), int'(sb.radius)),
                     pick_coord(int'(sb.height), int'(sb.radius)));
          sent++;
        end
        idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("[rounded_rect_antialias_pixel] OK");
    end else begin
      $display("[rounded_rect_antialias_pixel] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/rra_pkg.sv
rtl/core/rra_cover.sv
rtl/core/rounded_rect_antialias_pixel.sv
bench/tb_top.sv
